/* design/qte_pkg.sv */
// Shared types, widths and constants for the quaternion to Euler angle unit.
`timescale 1ns / 1ps

package qte_pkg;

   localparam int FIELD_W    = 16;  // input component and result field width
   localparam int PROD_W     = 32;  // 16 x 16 signed product
   localparam int ARG_W      = 34;  // atan2/asin arguments, 2^28 = 1.0
   localparam int ARG_FRAC   = 28;
   localparam int MAG_W      = 28;  // |asin argument| when not clamped
   localparam int SQ_W       = 58;  // square root remainder and root
   localparam int SQRT_STEPS = 29;  // one result bit per step
   localparam int SQRT_W     = 29;  // width of the final root
   localparam int CW         = 38;  // CORDIC x/y datapath
   localparam int ZW         = 34;  // angle accumulator, 2^31 = pi
   localparam int ZACC_FRAC  = 32;  // accumulator bits per full turn
   localparam int TAB_LEN    = 24;

   localparam logic signed [ARG_W-1:0] ONE_ARG   = 34'sd268435456;
   localparam logic        [SQ_W-1:0]  ONE_SQ    = SQ_W'(1) << (2 * ARG_FRAC);
   localparam logic signed [ZW-1:0]    QUARTER_Z = 34'sd1073741824;

   // atan(2^-i), 2^31 = pi
   localparam logic signed [ZW-1:0] ATAN_TAB [TAB_LEN] = '{
      34'sh020000000, 34'sh012E4051E, 34'sh009FB385B, 34'sh0051111D4,
      34'sh0028B0D43, 34'sh00145D7E1, 34'sh000A2F61E, 34'sh000517C55,
      34'sh00028BE53, 34'sh000145F2F, 34'sh0000A2F98, 34'sh0000517CC,
      34'sh000028BE6, 34'sh0000145F3, 34'sh00000A2FA, 34'sh00000517D,
      34'sh0000028BE, 34'sh00000145F, 34'sh000000A30, 34'sh000000518,
      34'sh00000028C, 34'sh000000146, 34'sh0000000A3, 34'sh000000051
   };

   typedef struct packed {
      logic signed [ARG_W-1:0] sr;
      logic signed [ARG_W-1:0] cr;
      logic signed [ARG_W-1:0] sy;
      logic signed [ARG_W-1:0] cy;
      logic signed [ARG_W-1:0] sp;
      logic                    clamp;
   } arg_set_type;

   typedef struct packed {
      logic [SQ_W-1:0] rem;
      logic [SQ_W-1:0] root;
   } sqrt_state_type;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [ZW-1:0] z;
      logic                 zero;
   } cordic_vec_type;

   typedef struct packed {
      logic clamp;
      logic neg;
   } pitch_meta_type;

   // quarter-turn pre-rotation into the right half plane
   function automatic cordic_vec_type cordic_prerot(input logic signed [CW-1:0] y,
                                                    input logic signed [CW-1:0] x);
      cordic_vec_type v;
      v.zero = (x == '0) && (y == '0);
      v.x    = x;
      v.y    = y;
      v.z    = '0;
      if (x < 0) begin
         if (y >= 0) begin
            v.x = y;
            v.y = -x;
            v.z = QUARTER_Z;
         end else begin
            v.x = -y;
            v.y = x;
            v.z = -QUARTER_Z;
         end
      end
      return v;
   endfunction

endpackage

/* design/qte_req_if.sv */
// Request channel: one quaternion word.
`timescale 1ns / 1ps

interface qte_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] comp_x;
   logic signed [15:0] comp_y;
   logic signed [15:0] comp_z;
   logic signed [15:0] comp_w;

   modport source (output valid, output comp_x, output comp_y, output comp_z,
                   output comp_w, input ready);
   modport sink   (input valid, input comp_x, input comp_y, input comp_z,
                   input comp_w, output ready);
endinterface

/* design/qte_rsp_if.sv */
// Response channel: one Euler angle word.
`timescale 1ns / 1ps

interface qte_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] roll_angle;
   logic signed [15:0] pitch_angle;
   logic signed [15:0] yaw_angle;
   logic               pitch_clamped;

   modport source (output valid, output roll_angle, output pitch_angle,
                   output yaw_angle, output pitch_clamped, input ready);
   modport sink   (input valid, input roll_angle, input pitch_angle,
                   input yaw_angle, input pitch_clamped, output ready);
endinterface

/* design/quaternion_to_euler_angles_unit.sv */
// Top level: quaternion (Q2.14) to roll, pitch and yaw binary angles, ZYX order.
`timescale 1ns / 1ps
//
// Usage
//   req_bus: one quaternion word (comp_x, comp_y, comp_z, comp_w, Q2.14) per
//   valid/ready handshake. rsp_bus: roll, pitch, yaw (2^(ANGLE_BITS-1) = pi)
//   and pitch_clamped, one word per request, in request order.
// Throughput: one word per cycle unless stalled; all stages move as one.
// Pipeline: 4 front stages (products, sums, clamp and square, 1 - s^2),
//   29 square root stages (one root bit each), one quarter-turn pre-rotation,
//   CORDIC_STEPS micro-rotations run for all three angles in parallel, one
//   rounding/output register.
// Stall: when the output word is held (valid and not ready) every stage
//   freezes and req_bus.ready drops in the same cycle; nothing is lost or
//   repeated. Bubbles travel as cleared valid bits.
// Reset: synchronous, clears all valid bits; the unit keeps no other state.
// Pitch: asin(s) = atan2(s, sqrt(1 - s^2)); |s| >= 1 gives a quarter turn
//   with the sign of s and sets pitch_clamped.
//
module quaternion_to_euler_angles_unit
   import qte_pkg::*;
#(
   parameter int CORDIC_STEPS = 16,
   parameter int ANGLE_BITS   = 16
) (
   input  logic      clock,
   input  logic      reset,
   qte_req_if.sink   req_bus,
   qte_rsp_if.source rsp_bus
);

   localparam int SH = ZACC_FRAC - ANGLE_BITS;
   localparam logic signed [ZW-1:0]         HALF_LSB    = ZW'(1) << (SH - 1);
   localparam logic signed [ANGLE_BITS-1:0] QUARTER_ANG = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

   // global pipeline advance: the output register is free or being taken
   logic advance;
   logic out_valid_ff;

   assign advance       = !out_valid_ff || rsp_bus.ready;
   assign req_bus.ready = advance;

   // front end
   logic        front_valid;
   arg_set_type front_args;
   logic [SQ_W-1:0] front_rem;

   qte_front u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_bus.valid),
      .comp_x    (req_bus.comp_x),
      .comp_y    (req_bus.comp_y),
      .comp_z    (req_bus.comp_z),
      .comp_w    (req_bus.comp_w),
      .out_valid (front_valid),
      .out_args  (front_args),
      .out_rem   (front_rem)
   );

   // square root pipeline; roll/yaw arguments ride alongside
   sqrt_state_type sq_st   [SQRT_STEPS+1];
   arg_set_type    sq_args [SQRT_STEPS+1];
   logic           sq_vld  [SQRT_STEPS+1];

   assign sq_st[0].rem  = front_rem;
   assign sq_st[0].root = '0;
   assign sq_args[0]    = front_args;
   assign sq_vld[0]     = front_valid;

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      arg_set_type args_ff;
      logic        vld_ff;

      qte_sqrt_stage #(.STEP(k)) u_stage (
         .clock   (clock),
         .advance (advance),
         .st_in   (sq_st[k]),
         .st_out  (sq_st[k+1])
      );

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else if (advance) begin
            vld_ff <= sq_vld[k];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            args_ff <= sq_args[k];
         end
      end

      assign sq_args[k+1] = args_ff;
      assign sq_vld[k+1]  = vld_ff;
   end

   // pre-rotation register, head of the CORDIC pipeline
   cordic_vec_type roll_v  [CORDIC_STEPS+1];
   cordic_vec_type pitch_v [CORDIC_STEPS+1];
   cordic_vec_type yaw_v   [CORDIC_STEPS+1];
   pitch_meta_type meta    [CORDIC_STEPS+1];
   logic           cv_vld  [CORDIC_STEPS+1];

   cordic_vec_type roll_pre_ff, pitch_pre_ff, yaw_pre_ff;
   pitch_meta_type meta_pre_ff;
   logic           pre_vld_ff;
   arg_set_type    a_fin;
   logic signed [CW-1:0] root_ext;

   assign a_fin    = sq_args[SQRT_STEPS];
   assign root_ext = CW'(sq_st[SQRT_STEPS].root[SQRT_W-1:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_vld_ff <= 1'b0;
      end else if (advance) begin
         pre_vld_ff <= sq_vld[SQRT_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         roll_pre_ff     <= cordic_prerot(CW'(a_fin.sr), CW'(a_fin.cr));
         yaw_pre_ff      <= cordic_prerot(CW'(a_fin.sy), CW'(a_fin.cy));
         pitch_pre_ff    <= cordic_prerot(CW'(a_fin.sp), root_ext);
         meta_pre_ff.clamp <= a_fin.clamp;
         meta_pre_ff.neg   <= a_fin.sp[ARG_W-1];
      end
   end

   assign roll_v[0]  = roll_pre_ff;
   assign pitch_v[0] = pitch_pre_ff;
   assign yaw_v[0]   = yaw_pre_ff;
   assign meta[0]    = meta_pre_ff;
   assign cv_vld[0]  = pre_vld_ff;

   // CORDIC micro-rotations, three angles per step
   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
      pitch_meta_type meta_ff;
      logic           vld_ff;

      qte_cordic_stage #(.STEP(k)) u_roll (
         .clock (clock), .advance (advance),
         .vec_in (roll_v[k]), .vec_out (roll_v[k+1])
      );
      qte_cordic_stage #(.STEP(k)) u_pitch (
         .clock (clock), .advance (advance),
         .vec_in (pitch_v[k]), .vec_out (pitch_v[k+1])
      );
      qte_cordic_stage #(.STEP(k)) u_yaw (
         .clock (clock), .advance (advance),
         .vec_in (yaw_v[k]), .vec_out (yaw_v[k+1])
      );

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else if (advance) begin
            vld_ff <= cv_vld[k];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            meta_ff <= meta[k];
         end
      end

      assign meta[k+1]   = meta_ff;
      assign cv_vld[k+1] = vld_ff;
   end

   // round half up to ANGLE_BITS, wrap, fit to the 16-bit field
   function automatic logic signed [FIELD_W-1:0] to_field(input cordic_vec_type v);
      logic signed [ZW-1:0]         zr;
      logic signed [ANGLE_BITS-1:0] a;
      zr = v.z + HALF_LSB;
      zr = zr >>> SH;
      a  = zr[ANGLE_BITS-1:0];
      if (v.zero) begin
         a = '0;
      end
      return FIELD_W'(a);
   endfunction

   logic signed [FIELD_W-1:0]    roll_in, pitch_in, yaw_in;
   logic signed [ANGLE_BITS-1:0] pitch_sat;
   logic signed [FIELD_W-1:0]    roll_ff, pitch_ff, yaw_ff;
   logic                         clamped_ff;

   always_comb begin
      roll_in   = to_field(roll_v[CORDIC_STEPS]);
      yaw_in    = to_field(yaw_v[CORDIC_STEPS]);
      pitch_sat = meta[CORDIC_STEPS].neg ? -QUARTER_ANG : QUARTER_ANG;
      if (meta[CORDIC_STEPS].clamp) begin
         pitch_in = FIELD_W'(pitch_sat);
      end else begin
         pitch_in = to_field(pitch_v[CORDIC_STEPS]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= cv_vld[CORDIC_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         roll_ff    <= roll_in;
         pitch_ff   <= pitch_in;
         yaw_ff     <= yaw_in;
         clamped_ff <= meta[CORDIC_STEPS].clamp;
      end
   end

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.roll_angle    = roll_ff;
   assign rsp_bus.pitch_angle   = pitch_ff;
   assign rsp_bus.yaw_angle     = yaw_ff;
   assign rsp_bus.pitch_clamped = clamped_ff;

endmodule

/* design/qte_front.sv */
// Front end: products, atan2/asin arguments, clamp test and 1 - s^2.
`timescale 1ns / 1ps

module qte_front
   import qte_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic                     in_valid,
   input  logic signed [FIELD_W-1:0] comp_x,
   input  logic signed [FIELD_W-1:0] comp_y,
   input  logic signed [FIELD_W-1:0] comp_z,
   input  logic signed [FIELD_W-1:0] comp_w,
   output logic                     out_valid,
   output arg_set_type              out_args,
   output logic [SQ_W-1:0]          out_rem
);

   logic [3:0] vld_ff;

   logic signed [PROD_W-1:0] p_wx_ff, p_yz_ff, p_xx_ff, p_yy_ff, p_wy_ff;
   logic signed [PROD_W-1:0] p_zx_ff, p_wz_ff, p_xy_ff, p_zz_ff;

   arg_set_type args2_ff, args2_in;
   arg_set_type args3_ff, args3_in;
   arg_set_type args4_ff;
   logic [2*MAG_W-1:0] sq3_ff;
   logic [SQ_W-1:0]    rem4_ff;

   logic signed [ARG_W-1:0] sp_abs;
   logic [MAG_W-1:0]        mag_op;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[2:0], in_valid};
      end
   end

   always_comb begin
      args2_in.sr    = (ARG_W'(p_wx_ff) + ARG_W'(p_yz_ff)) <<< 1;
      args2_in.cr    = ONE_ARG - ((ARG_W'(p_xx_ff) + ARG_W'(p_yy_ff)) <<< 1);
      args2_in.sp    = (ARG_W'(p_wy_ff) - ARG_W'(p_zx_ff)) <<< 1;
      args2_in.sy    = (ARG_W'(p_wz_ff) + ARG_W'(p_xy_ff)) <<< 1;
      args2_in.cy    = ONE_ARG - ((ARG_W'(p_yy_ff) + ARG_W'(p_zz_ff)) <<< 1);
      args2_in.clamp = 1'b0;
   end

   always_comb begin
      args3_in       = args2_ff;
      args3_in.clamp = (args2_ff.sp >= ONE_ARG) || (args2_ff.sp <= -ONE_ARG);
      sp_abs         = (args2_ff.sp < 0) ? -args2_ff.sp : args2_ff.sp;
      mag_op         = args3_in.clamp ? '0 : sp_abs[MAG_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p_wx_ff  <= comp_w * comp_x;
         p_yz_ff  <= comp_y * comp_z;
         p_xx_ff  <= comp_x * comp_x;
         p_yy_ff  <= comp_y * comp_y;
         p_wy_ff  <= comp_w * comp_y;
         p_zx_ff  <= comp_z * comp_x;
         p_wz_ff  <= comp_w * comp_z;
         p_xy_ff  <= comp_x * comp_y;
         p_zz_ff  <= comp_z * comp_z;
         args2_ff <= args2_in;
         args3_ff <= args3_in;
         sq3_ff   <= mag_op * mag_op;
         args4_ff <= args3_ff;
         rem4_ff  <= ONE_SQ - SQ_W'(sq3_ff);
      end
   end

   assign out_valid = vld_ff[3];
   assign out_args  = args4_ff;
   assign out_rem   = rem4_ff;

endmodule

/* design/qte_sqrt_stage.sv */
// One step of the bit-per-stage integer square root.
`timescale 1ns / 1ps

module qte_sqrt_stage
   import qte_pkg::*;
#(
   parameter int STEP = 0
) (
   input  logic           clock,
   input  logic           advance,
   input  sqrt_state_type st_in,
   output sqrt_state_type st_out
);

   localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQRT_STEPS - 1 - STEP));

   sqrt_state_type st_ff, st_in_next;
   logic [SQ_W-1:0] trial;

   always_comb begin
      trial = st_in.root + BIT;
      if (st_in.rem >= trial) begin
         st_in_next.rem  = st_in.rem - trial;
         st_in_next.root = (st_in.root >> 1) + BIT;
      end else begin
         st_in_next.rem  = st_in.rem;
         st_in_next.root = st_in.root >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         st_ff <= st_in_next;
      end
   end

   assign st_out = st_ff;

endmodule

/* design/qte_cordic_stage.sv */
// One vectoring CORDIC micro-rotation, registered.
`timescale 1ns / 1ps

module qte_cordic_stage
   import qte_pkg::*;
#(
   parameter int STEP = 0
) (
   input  logic           clock,
   input  logic           advance,
   input  cordic_vec_type vec_in,
   output cordic_vec_type vec_out
);

   cordic_vec_type vec_ff, vec_in_next;
   logic signed [CW-1:0] dx, dy;

   always_comb begin
      dx               = vec_in.y >>> STEP;
      dy               = vec_in.x >>> STEP;
      vec_in_next.zero = vec_in.zero;
      if (vec_in.y >= 0) begin
         vec_in_next.x = vec_in.x + dx;
         vec_in_next.y = vec_in.y - dy;
         vec_in_next.z = vec_in.z + ATAN_TAB[STEP];
      end else begin
         vec_in_next.x = vec_in.x - dx;
         vec_in_next.y = vec_in.y + dy;
         vec_in_next.z = vec_in.z - ATAN_TAB[STEP];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         vec_ff <= vec_in_next;
      end
   end

   assign vec_out = vec_ff;

endmodule
